>>> hw/rtl/sphere_sphere_contact_assert.svh
// ----------------------------------------------------------------------------
// Sphere contact assertion macros
// Short forms for the concurrent checks on the sphere contact ports.
// ----------------------------------------------------------------------------
`ifndef SPHERE_SPHERE_CONTACT_ASSERT_SVH
`define SPHERE_SPHERE_CONTACT_ASSERT_SVH

// Same-cycle implication, sampled on aclk.
`define SSC_ASSERT_NOW(lbl, dis, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk.
`define SSC_ASSERT_NEXT(lbl, dis, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// Sphere contact package
// Stage layout, the word carried down the pipeline and shared constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 17;
    localparam int ST_SQRT0   = 4;
    localparam int ST_EVAL    = ST_SQRT0 + SQRT_STEPS;
    localparam int ST_DIV0    = ST_EVAL + 1;
    localparam int N_STAGES   = ST_DIV0 + DIV_STEPS;

    localparam int S_DATA_W = 288;
    localparam int M_DATA_W = 216;

    localparam logic [17:0] NORMAL_ONE = 18'h10000;

    typedef struct packed {
        logic [15:0]       tag_a;
        logic [15:0]       tag_b;
        logic [2:0][31:0]  mid;
        logic [2:0][32:0]  delta;
        logic [2:0]        neg;
        logic [2:0][31:0]  mag;
        logic              sat;
        logic [31:0]       rsum;
        logic [2:0][63:0]  sq;
        logic [63:0]       s;
        logic [33:0]       rem;
        logic [31:0]       root;
        logic              contact;
        logic              dzero;
        logic [31:0]       pen;
        logic [2:0][47:0]  drem;
        logic [2:0][16:0]  quo;
    } item_t;

endpackage

`default_nettype wire

>>> hw/rtl/ssc_sqrt_step.sv
// ----------------------------------------------------------------------------
// Square root step
// One digit of the restoring integer square root: takes two radicand bits,
// yields one root bit.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_sqrt_step (
    input  wire logic [33:0] rem_in,
    input  wire logic [31:0] root_in,
    input  wire logic [1:0]  pair,
    output logic      [33:0] rem_out,
    output logic      [31:0] root_out
);

    logic [35:0] trial_rem;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;

    always_comb begin
        trial_rem = {rem_in, pair};
        trial     = {2'b00, root_in, 2'b01};
        diff      = trial_rem - trial;
        ge        = trial_rem >= trial;
        rem_out   = ge ? diff[33:0] : trial_rem[33:0];
        root_out  = {root_in[30:0], ge};
    end

endmodule

`default_nettype wire

>>> hw/rtl/sphere_sphere_contact.sv
// ----------------------------------------------------------------------------
// Sphere-sphere contact
// Narrow-phase contact generation for one sphere pair per word.
// ----------------------------------------------------------------------------
// One pair enters per cycle while the output is not stalled, and its contact,
// if any, leaves after four setup stages (differences, magnitudes, squares,
// sum), 32 square-root stages producing one gap bit each, one compare stage,
// 17 divider stages producing one normal bit each for all three axes, and the
// output register. Pairs without contact leave a gap in the output stream.
// The whole pipeline holds while a finished contact waits on m_tready.
`default_nettype none

module sphere_sphere_contact (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // body_a_tag, body_b_tag, center_a_x/y/z, center_b_x/y/z, radius_a,
    // radius_b, zero pad
    input  wire logic [ssc_pkg::S_DATA_W-1:0] s_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // contact_body_a, contact_body_b, point_x/y/z, normal_x/y/z,
    // penetration, zero pad
    output logic      [ssc_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int N = ssc_pkg::N_STAGES;

    ssc_pkg::item_t pipe_reg [0:N-1];
    logic [N-1:0]   valid_reg;

    logic                        adv;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic [ssc_pkg::M_DATA_W-1:0] m_data_reg;
    logic [ssc_pkg::M_DATA_W-1:0] m_data_next;

    // Advance everything when the output register is free or being drained.
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : gen_stage
            ssc_pkg::item_t stage_next;

            if (g == 0) begin : gen_in
                logic [2:0][32:0] a_ext;
                logic [2:0][32:0] b_ext;
                logic [2:0][32:0] sum_ab;
                always_comb begin
                    stage_next = '0;
                    for (int i = 0; i < 3; i++) begin
                        a_ext[i]  = {s_tdata[32*i+63], s_tdata[32*i+32 +: 32]};
                        b_ext[i]  = {s_tdata[32*i+159], s_tdata[32*i+128 +: 32]};
                        sum_ab[i] = a_ext[i] + b_ext[i];
                        stage_next.delta[i] = b_ext[i] - a_ext[i];
                        stage_next.mid[i]   = sum_ab[i][32:1];
                    end
                    stage_next.tag_a = s_tdata[15:0];
                    stage_next.tag_b = s_tdata[31:16];
                    stage_next.rsum  = {1'b0, s_tdata[254:224]} + {1'b0, s_tdata[285:255]};
                end
            end else if (g == 1) begin : gen_mag
                logic [2:0][32:0] m33;
                always_comb begin
                    stage_next = pipe_reg[g-1];
                    for (int i = 0; i < 3; i++) begin
                        stage_next.neg[i] = pipe_reg[g-1].delta[i][32];
                        m33[i] = pipe_reg[g-1].delta[i][32] ? 33'd0 - pipe_reg[g-1].delta[i]
                                                           : pipe_reg[g-1].delta[i];
                        stage_next.mag[i] = m33[i][31:0];
                    end
                    // a gap component of 2^32 or more cannot touch
                    stage_next.sat = m33[0][32] | m33[1][32] | m33[2][32];
                end
            end else if (g == 2) begin : gen_sq
                always_comb begin
                    stage_next = pipe_reg[g-1];
                    for (int i = 0; i < 3; i++) begin
                        stage_next.sq[i] = 64'(pipe_reg[g-1].mag[i]) *
                                           64'(pipe_reg[g-1].mag[i]);
                    end
                end
            end else if (g == 3) begin : gen_sum
                logic [65:0] total;
                always_comb begin
                    stage_next = pipe_reg[g-1];
                    total = {2'b00, pipe_reg[g-1].sq[0]} + {2'b00, pipe_reg[g-1].sq[1]}
                          + {2'b00, pipe_reg[g-1].sq[2]};
                    stage_next.s    = total[63:0];
                    stage_next.sat  = pipe_reg[g-1].sat | (|total[65:64]);
                    stage_next.rem  = '0;
                    stage_next.root = '0;
                end
            end else if (g < ssc_pkg::ST_EVAL) begin : gen_sqrt
                localparam int J = g - ssc_pkg::ST_SQRT0;
                logic [33:0] rem_o;
                logic [31:0] root_o;
                ssc_sqrt_step u_step (
                    .rem_in   (pipe_reg[g-1].rem),
                    .root_in  (pipe_reg[g-1].root),
                    .pair     (pipe_reg[g-1].s[63-2*J -: 2]),
                    .rem_out  (rem_o),
                    .root_out (root_o)
                );
                always_comb begin
                    stage_next      = pipe_reg[g-1];
                    stage_next.rem  = rem_o;
                    stage_next.root = root_o;
                end
            end else if (g == ssc_pkg::ST_EVAL) begin : gen_eval
                always_comb begin
                    stage_next = pipe_reg[g-1];
                    stage_next.contact = !pipe_reg[g-1].sat &&
                                         (pipe_reg[g-1].root < pipe_reg[g-1].rsum);
                    stage_next.pen     = pipe_reg[g-1].rsum - pipe_reg[g-1].root;
                    stage_next.dzero   = pipe_reg[g-1].root == '0;
                    for (int i = 0; i < 3; i++) begin
                        stage_next.drem[i] = {pipe_reg[g-1].mag[i], 16'h0000};
                    end
                    stage_next.quo = '0;
                end
            end else begin : gen_div
                localparam int K = ssc_pkg::DIV_STEPS - 1 - (g - ssc_pkg::ST_DIV0);
                logic [47:0] dsh;
                always_comb begin
                    stage_next = pipe_reg[g-1];
                    dsh = 48'(pipe_reg[g-1].root) << K;
                    for (int i = 0; i < 3; i++) begin
                        if (pipe_reg[g-1].drem[i] >= dsh) begin
                            stage_next.drem[i]   = pipe_reg[g-1].drem[i] - dsh;
                            stage_next.quo[i][K] = 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    pipe_reg[g] <= stage_next;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[g] <= 1'b0;
                end else if (adv) begin
                    if (g == 0) begin
                        valid_reg[g] <= s_tvalid;
                    end else begin
                        valid_reg[g] <= valid_reg[(g == 0) ? 0 : g-1];
                    end
                end
            end
        end
    endgenerate

    // Output word: restore signs, replace the normal for coincident centers.
    logic [2:0][17:0] nrm;
    logic [17:0]      q18;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q18    = {1'b0, pipe_reg[N-1].quo[i]};
            nrm[i] = pipe_reg[N-1].neg[i] ? 18'd0 - q18 : q18;
        end
        if (pipe_reg[N-1].dzero) begin
            nrm[0] = ssc_pkg::NORMAL_ONE;
            nrm[1] = '0;
            nrm[2] = '0;
        end
        m_valid_next = valid_reg[N-1] && pipe_reg[N-1].contact;
        m_data_next  = {2'b00, pipe_reg[N-1].pen, nrm[2], nrm[1], nrm[0],
                        pipe_reg[N-1].mid[2], pipe_reg[N-1].mid[1], pipe_reg[N-1].mid[0],
                        pipe_reg[N-1].tag_b, pipe_reg[N-1].tag_a};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ssc_checker.sv
// ----------------------------------------------------------------------------
// Sphere contact port checker
// Watches the sphere contact ports and flags words that break its contract.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sphere_sphere_contact_assert.svh"

module ssc_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [ssc_pkg::M_DATA_W-1:0] m_tdata
);

    logic [17:0] nx;
    logic [31:0] pen;

    assign nx  = m_tdata[145:128];
    assign pen = m_tdata[213:182];

    `SSC_ASSERT_NEXT(a_hold, !aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")
    `SSC_ASSERT_NEXT(a_reset, 1'b0, !aresetn, !m_tvalid, "output valid after reset")
    `SSC_ASSERT_NOW(a_pen, !aresetn, m_tvalid, pen != 32'd0, "contact with zero penetration")
    `SSC_ASSERT_NOW(a_nrm, !aresetn, m_tvalid, nx[17:16] == 2'b00 || nx[17:16] == 2'b11 || nx == 18'h10000 || nx == 18'h30000, "normal x out of unit range")
    `SSC_ASSERT_NOW(a_stall, !aresetn, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")

endmodule

bind sphere_sphere_contact ssc_checker u_ssc_checker (.*);

`default_nettype wire
